FILE: hw/rtl/sdff_pkg.sv
// ----------------------------------------------------------------------------
// sdff_pkg
// Shared constants, types and helpers of the signed decimal field formatter.
// ----------------------------------------------------------------------------
package sdff_pkg;

  localparam int ValueBits = 32;
  localparam int MaxField  = 64;

  // port widths of the request and result fields
  localparam int FieldWidthBits = 7;
  localparam int PrecBits       = 6;
  localparam int CharBits       = 8;
  localparam int CountBits      = 7;

  // decimal digits needed for the largest magnitude, 2**(ValueBits-1)
  function automatic int num_digits(int bits);
    longint unsigned top;
    longint unsigned lim;
    int              n;
    top = 64'd1 << (bits - 1);
    lim = 64'd10;
    n   = 1;
    for (int i = 0; i < 19; i++) begin
      if (lim <= top) begin
        n   = n + 1;
        lim = lim * 64'd10;
      end
    end
    return n;
  endfunction

  localparam int NumDigits   = num_digits(ValueBits);
  localparam int BcdBits     = 4 * NumDigits;
  localparam int DigIdxBits  = $clog2(NumDigits);

  // double-dabble split over equal register stages
  localparam int DabStages    = 4;
  localparam int BitsPerStage = (ValueBits + DabStages - 1) / DabStages;
  localparam int PadBits      = BitsPerStage * DabStages;

  localparam int PrecMax = (1 << PrecBits) - 1;
  localparam int BodyMax = 1 + ((PrecMax > NumDigits) ? PrecMax : NumDigits);
  localparam int LenMax  = (BodyMax > MaxField) ? BodyMax : MaxField;
  localparam int LenBits = $clog2(LenMax + 1);

  localparam logic [CharBits-1:0] CharSpace = 8'h20;
  localparam logic [CharBits-1:0] CharMinus = 8'h2D;
  localparam logic [CharBits-1:0] CharZero  = 8'h30;

  typedef struct packed {
    logic                 neg;
    logic                 supp;
    logic [LenBits-1:0]   width;
    logic [PrecBits-1:0]  prec;
    logic [PadBits-1:0]   sh;
    logic [BcdBits-1:0]   bcd;
  } dab_t;

  typedef struct packed {
    logic [NumDigits-1:0][3:0] dig;
    logic                      sign;
    logic [LenBits-1:0]        spaces;
    logic [LenBits-1:0]        zero_end;
    logic [LenBits-1:0]        total;
    logic [CountBits-1:0]      n;
  } lay_t;

endpackage

FILE: hw/rtl/sdff_prep.sv
// ----------------------------------------------------------------------------
// sdff_prep
// Entry stage: sign, magnitude, clamped width, precision and zero suppression.
// ----------------------------------------------------------------------------
module sdff_prep (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [sdff_pkg::ValueBits-1:0] value_i,
  input  logic                              width_given_i,
  input  logic [sdff_pkg::FieldWidthBits-1:0] field_width_i,
  input  logic                              prec_given_i,
  input  logic [sdff_pkg::PrecBits-1:0]     prec_digits_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sdff_pkg::dab_t                    out_o
);

  logic           vld_q;
  sdff_pkg::dab_t data_q, data_d;

  logic [sdff_pkg::ValueBits-1:0] raw;
  logic [sdff_pkg::ValueBits-1:0] mag;
  logic [sdff_pkg::LenBits-1:0]   fw;

  always_comb begin
    raw = sdff_pkg::ValueBits'(value_i);
    mag = raw[sdff_pkg::ValueBits-1] ? (~raw + 1'b1) : raw;
    fw  = sdff_pkg::LenBits'(field_width_i);

    data_d.neg  = raw[sdff_pkg::ValueBits-1];
    data_d.prec = prec_given_i ? prec_digits_i : '0;
    data_d.supp = prec_given_i && (prec_digits_i == '0) && (raw == '0);
    if (!width_given_i) begin
      data_d.width = '0;
    end else if (fw > sdff_pkg::LenBits'(sdff_pkg::MaxField)) begin
      data_d.width = sdff_pkg::LenBits'(sdff_pkg::MaxField);
    end else begin
      data_d.width = fw;
    end
    data_d.sh  = sdff_pkg::PadBits'(mag);
    data_d.bcd = '0;
  end

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: hw/rtl/sdff_dabble.sv
// ----------------------------------------------------------------------------
// sdff_dabble
// One register stage of the binary to BCD shift-and-add-3 conversion.
// ----------------------------------------------------------------------------
module sdff_dabble (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sdff_pkg::dab_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sdff_pkg::dab_t out_o
);

  logic           vld_q;
  sdff_pkg::dab_t data_q, data_d;

  logic [sdff_pkg::BcdBits+sdff_pkg::PadBits-1:0] cat;

  always_comb begin
    data_d = in_i;
    cat    = {in_i.bcd, in_i.sh};
    for (int s = 0; s < sdff_pkg::BitsPerStage; s++) begin
      for (int d = 0; d < sdff_pkg::NumDigits; d++) begin
        if (cat[sdff_pkg::PadBits + 4*d +: 4] >= 4'd5) begin
          cat[sdff_pkg::PadBits + 4*d +: 4] = cat[sdff_pkg::PadBits + 4*d +: 4] + 4'd3;
        end
      end
      cat = cat << 1;
    end
    data_d.bcd = cat[sdff_pkg::PadBits +: sdff_pkg::BcdBits];
    data_d.sh  = cat[sdff_pkg::PadBits-1:0];
  end

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: hw/rtl/sdff_layout.sv
// ----------------------------------------------------------------------------
// sdff_layout
// Digit count and the boundaries of the space, sign, zero and digit runs.
// ----------------------------------------------------------------------------
module sdff_layout (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sdff_pkg::dab_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sdff_pkg::lay_t out_o
);

  logic           vld_q;
  sdff_pkg::lay_t data_q, data_d;

  logic [sdff_pkg::LenBits-1:0] ndig;
  logic [sdff_pkg::LenBits-1:0] prec;
  logic [sdff_pkg::LenBits-1:0] zeros;
  logic [sdff_pkg::LenBits-1:0] body;
  logic                         sign;

  always_comb begin
    data_d.dig = in_i.bcd;

    // highest non-zero digit; zero still prints one digit
    ndig = sdff_pkg::LenBits'(1);
    for (int d = 1; d < sdff_pkg::NumDigits; d++) begin
      if (in_i.bcd[4*d +: 4] != 4'd0) begin
        ndig = sdff_pkg::LenBits'(d + 1);
      end
    end
    if (in_i.supp) begin
      ndig = '0;
    end

    sign  = in_i.neg && !in_i.supp;
    prec  = sdff_pkg::LenBits'(in_i.prec);
    zeros = (!in_i.supp && (prec > ndig)) ? (prec - ndig) : '0;
    body  = sdff_pkg::LenBits'(sign) + zeros + ndig;

    data_d.sign     = sign;
    data_d.spaces   = (in_i.width > body) ? (in_i.width - body) : '0;
    data_d.zero_end = data_d.spaces + sdff_pkg::LenBits'(sign) + zeros;
    data_d.total    = data_d.spaces + body;
    data_d.n        = (data_d.total > sdff_pkg::LenBits'(sdff_pkg::MaxField))
                    ? sdff_pkg::CountBits'(sdff_pkg::MaxField)
                    : sdff_pkg::CountBits'(data_d.total);
  end

  assign in_ready_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: hw/rtl/sdff_emit.sv
// ----------------------------------------------------------------------------
// sdff_emit
// Character sequencer: walks one conversion a character per cycle, while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module sdff_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sdff_pkg::lay_t                  in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sdff_pkg::CharBits-1:0]   char_out_o,
  output logic                            last_char_o,
  output logic [sdff_pkg::CountBits-1:0]  total_count_o
);

  logic                           busy_q, busy_d;
  logic [sdff_pkg::CountBits-1:0] pos_q, pos_d;
  sdff_pkg::lay_t                 item_q;

  logic                           ovld_q, ovld_d;
  logic [sdff_pkg::CharBits-1:0]  char_q, char_d;
  logic                           last_q, last_d;
  logic [sdff_pkg::CountBits-1:0] cnt_q, cnt_d;

  logic                            out_load;
  logic                            take;
  logic [sdff_pkg::LenBits-1:0]    posl;
  logic [sdff_pkg::DigIdxBits-1:0] idx;

  assign out_load   = busy_q && (!ovld_q || !out_stall_i);
  assign in_ready_o = !busy_q || (out_load && last_d);
  assign take       = in_ready_o && in_valid_i;

  always_comb begin
    posl   = sdff_pkg::LenBits'(pos_q);
    idx    = sdff_pkg::DigIdxBits'(item_q.total - sdff_pkg::LenBits'(1) - posl);
    last_d = (sdff_pkg::CountBits'(pos_q + 1'b1) == item_q.n);
    cnt_d  = last_d ? item_q.n : '0;

    if (posl < item_q.spaces) begin
      char_d = sdff_pkg::CharSpace;
    end else if (item_q.sign && (posl == item_q.spaces)) begin
      char_d = sdff_pkg::CharMinus;
    end else if (posl < item_q.zero_end) begin
      char_d = sdff_pkg::CharZero;
    end else begin
      char_d = sdff_pkg::CharZero + sdff_pkg::CharBits'(item_q.dig[idx]);
    end
  end

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    if (out_load) begin
      pos_d = pos_q + 1'b1;
      if (last_d) begin
        busy_d = 1'b0;
      end
    end
    // an empty conversion is taken and dropped
    if (take) begin
      busy_d = (in_i.n != '0);
      pos_d  = '0;
    end

    if (out_load) begin
      ovld_d = 1'b1;
    end else if (!out_stall_i) begin
      ovld_d = 1'b0;
    end else begin
      ovld_d = ovld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_i;
    end
    if (out_load) begin
      char_q <= char_d;
      last_q <= last_d;
      cnt_q  <= cnt_d;
    end
  end

  assign out_valid_o   = ovld_q;
  assign char_out_o    = char_q;
  assign last_char_o   = last_q;
  assign total_count_o = cnt_q;

endmodule

FILE: hw/rtl/signed_decimal_field_formatter_top.sv
// The formatter prints one signed integer per request as a "%d" conversion
// with optional field width and precision, one ASCII character per result,
// the last one flagged and carrying the character count. A request passes six
// register stages (entry, four shift-and-add-3 BCD stages, layout) and then
// the character sequencer, which sends one character per cycle while the
// output is not stalled; a conversion of up to 64 characters holds the
// sequencer until its last character is sent, so the sustained rate is set by
// the output side. The pipeline keeps taking requests while the sequencer
// is busy until its stages fill, and consecutive conversions that are waiting
// leave the block with no gap between them, unless one of them prints nothing.
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter_top
// Signed decimal formatter with width and precision, streaming characters.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [sdff_pkg::ValueBits-1:0] value_i,
  input  logic                                  width_given_i,
  input  logic [sdff_pkg::FieldWidthBits-1:0]   field_width_i,
  input  logic                                  prec_given_i,
  input  logic [sdff_pkg::PrecBits-1:0]         prec_digits_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [sdff_pkg::CharBits-1:0]         char_out_o,
  output logic                                  last_char_o,
  output logic [sdff_pkg::CountBits-1:0]        total_count_o
);

  logic           in_ready;
  logic           dab_vld [sdff_pkg::DabStages+1];
  logic           dab_rdy [sdff_pkg::DabStages+1];
  sdff_pkg::dab_t dab     [sdff_pkg::DabStages+1];

  logic           lay_vld, lay_rdy;
  sdff_pkg::lay_t lay;

  assign in_stall_o = !in_ready;

  sdff_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready),
    .value_i       (value_i),
    .width_given_i (width_given_i),
    .field_width_i (field_width_i),
    .prec_given_i  (prec_given_i),
    .prec_digits_i (prec_digits_i),
    .out_valid_o   (dab_vld[0]),
    .out_ready_i   (dab_rdy[0]),
    .out_o         (dab[0])
  );

  for (genvar g = 0; g < sdff_pkg::DabStages; g++) begin : g_dab
    sdff_dabble u_dabble (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dab_vld[g]),
      .in_ready_o  (dab_rdy[g]),
      .in_i        (dab[g]),
      .out_valid_o (dab_vld[g+1]),
      .out_ready_i (dab_rdy[g+1]),
      .out_o       (dab[g+1])
    );
  end

  sdff_layout u_layout (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dab_vld[sdff_pkg::DabStages]),
    .in_ready_o  (dab_rdy[sdff_pkg::DabStages]),
    .in_i        (dab[sdff_pkg::DabStages]),
    .out_valid_o (lay_vld),
    .out_ready_i (lay_rdy),
    .out_o       (lay)
  );

  sdff_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (lay_vld),
    .in_ready_o    (lay_rdy),
    .in_i          (lay),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_out_o    (char_out_o),
    .last_char_o   (last_char_o),
    .total_count_o (total_count_o)
  );

  // count only rides on the closing character, and is never zero there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_char_o |-> total_count_o != '0)
    else $error("last character without a count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_char_o |-> total_count_o == '0)
    else $error("count on a character that is not the last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_out_o == sdff_pkg::CharSpace) ||
                    (char_out_o == sdff_pkg::CharMinus) ||
                    ((char_out_o >= sdff_pkg::CharZero) &&
                     (char_out_o <= sdff_pkg::CharZero + 8'd9)))
    else $error("character outside the printable set");

endmodule
